FILE: src/lfu_pkg.sv
// shared types and constants for the lfu cache with lru tie-break
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

  localparam int CFG_BITS       = 5;
  localparam int KEY_BITS       = 32;
  localparam int DATA_BITS      = 32;
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                        op;
    logic signed [KEY_BITS-1:0]  key;
    logic signed [DATA_BITS-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic                        hit;
    logic signed [DATA_BITS-1:0] data_out;
    logic                        evicted;
    logic                        stored;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } lfu_state_e;

  // write strobes into the entry store
  typedef struct packed {
    logic key_we;
    logic value_we;
    logic count_we;
    logic rank_we;
  } store_we_t;

  // how the rank pass adjusts ranks
  typedef struct packed {
    logic touch;
    logic evict;
  } upd_mode_t;

  // per-entry compare flags from the shared unit
  typedef struct packed {
    logic match;
    logic better;
  } scan_flags_t;

endpackage

`default_nettype wire

FILE: src/lfu_cache_replacement.sv
// top level of the lfu cache with lru tie-break: sequencer, valid bits, result register
// depends on lfu_pkg, lfu_entry_store, lfu_entry_unit
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (op, key, data_in)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (hit, data_out, evicted, stored)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (capacity_in_use)
//
//  an item goes from accept to result through a scan over the single store read port,
//  a decide step, a rank pass through the same port and a result load; the next accept
//  is taken in the idle state that follows
//  gets that miss and puts at capacity zero skip the rank pass
//  after reset the cache is empty and capacity is 16; no clearing pass is needed
//  a waiting result stalls only the finish of the next item, not its accept

module lfu_cache_replacement #(
  parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire lfu_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output lfu_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lfu_pkg::CFG_BITS-1:0]  cfg_data_i
);
  import lfu_pkg::*;

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
  localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(ENTRIES);

  // sequencer
  lfu_state_e state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q;
  logic                rd_ok_q;
  logic [IDX_BITS-1:0] rd_idx_q;

  // architectural state
  logic [ENTRIES-1:0]  valid_q;
  logic [CNT_BITS-1:0] occ_q;
  logic [CFG_BITS-1:0] cap_q;

  // item and scan results
  in_item_t              item_q;
  logic                  found_q, vic_ok_q, free_ok_q;
  logic [IDX_BITS-1:0]   found_idx_q, vic_idx_q, free_idx_q;
  logic [COUNT_BITS-1:0] found_cnt_q, vic_cnt_q;
  logic [IDX_BITS-1:0]   found_rank_q, vic_rank_q;
  logic [DATA_BITS-1:0]  found_val_q;

  // decided update
  logic [IDX_BITS-1:0] slot_q, ref_rank_q;
  upd_mode_t           mode_q;
  out_item_t           res_q;

  // result register
  logic      out_valid_q;
  out_item_t out_q;

  // store ports
  logic                  rd_en;
  logic [IDX_BITS-1:0]   rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [DATA_BITS-1:0]  rd_value;
  logic [COUNT_BITS-1:0] rd_count;
  logic [IDX_BITS-1:0]   rd_rank;
  store_we_t             store_we;
  logic [COUNT_BITS-1:0] wr_count;
  logic [IDX_BITS-1:0]   wr_rank;

  // shared unit
  scan_flags_t         flags;
  logic [IDX_BITS-1:0] new_rank;
  logic                ent_valid;

  // decision terms
  logic [CMP_BITS-1:0] cap_ext, cap_eff;
  logic                is_put, cap_zero, act_touch, act_insert, need_evict;
  logic [IDX_BITS-1:0] ins_slot, dec_slot, dec_ref;
  out_item_t           dec_res;
  logic                load_out, scanning, cnt_run;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign ent_valid   = valid_q[rd_idx_q];
  assign cnt_run     = cnt_q != LAST_CNT;
  assign scanning    = (state_q == ST_SCAN) && rd_ok_q;

  // effective capacity saturates at the number of entries
  always_comb begin
    cap_ext = CMP_BITS'(cap_q);
    cap_eff = (cap_ext > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_ext;
  end

  // outcome of one item, taken from the scan
  always_comb begin
    is_put     = item_q.op == OP_PUT;
    cap_zero   = cap_eff == '0;
    act_touch  = found_q && (!is_put || !cap_zero);
    act_insert = is_put && !cap_zero && !found_q;
    // full, or capacity lowered below occupancy
    need_evict = act_insert && vic_ok_q &&
                 ((CMP_BITS'(occ_q) >= cap_eff) || !free_ok_q);
    // after removing the victim the lowest free index is the new slot
    if (need_evict) begin
      ins_slot = (free_ok_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q;
    end else begin
      ins_slot = free_idx_q;
    end
    dec_slot = act_touch ? found_idx_q : ins_slot;
    dec_ref  = act_touch ? found_rank_q : vic_rank_q;
    dec_res.hit      = act_touch;
    dec_res.data_out = (!is_put && found_q) ? found_val_q : '0;
    dec_res.evicted  = need_evict;
    dec_res.stored   = is_put && !cap_zero;
    if (act_touch) begin
      wr_count = found_cnt_q + COUNT_BITS'(found_cnt_q != '1);
    end else begin
      wr_count = COUNT_BITS'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!cnt_run) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = (act_touch || act_insert) ? ST_UPDATE : ST_FINISH;
      end
      ST_UPDATE: begin
        if (!cnt_run) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cnt_q[IDX_BITS-1:0];
    store_we   = '0;
    wr_rank    = (rd_idx_q == slot_q) ? '0 : new_rank;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SCAN: begin
        rd_en = cnt_run;
      end
      ST_DECIDE: begin
        store_we.key_we   = act_insert;
        store_we.value_we = is_put && (act_touch || act_insert);
        store_we.count_we = act_touch || act_insert;
      end
      ST_UPDATE: begin
        rd_en            = cnt_run;
        store_we.rank_we = rd_ok_q && ((rd_idx_q == slot_q) || ent_valid);
      end
      ST_FINISH: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_ok_q     <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= CAP_RESET;
      found_q     <= 1'b0;
      vic_ok_q    <= 1'b0;
      free_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= rd_en;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        cnt_q     <= '0;
        found_q   <= 1'b0;
        vic_ok_q  <= 1'b0;
        free_ok_q <= 1'b0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
      end
      // scan trackers
      if (scanning) begin
        if (flags.match && !found_q) found_q <= 1'b1;
        if (flags.better) vic_ok_q <= 1'b1;
        if (!ent_valid) free_ok_q <= 1'b1;
      end
      if (state_q == ST_DECIDE) begin
        cnt_q <= '0;
        if (act_insert) begin
          if (need_evict) begin
            // a victim reused as the new slot stays valid
            if (vic_idx_q != ins_slot) valid_q[vic_idx_q] <= 1'b0;
          end else begin
            occ_q <= occ_q + CNT_BITS'(1);
          end
          valid_q[ins_slot] <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
    rd_idx_q <= rd_addr;
    if (scanning) begin
      if (flags.match && !found_q) begin
        found_idx_q  <= rd_idx_q;
        found_cnt_q  <= rd_count;
        found_rank_q <= rd_rank;
        found_val_q  <= rd_value;
      end
      if (flags.better) begin
        vic_idx_q  <= rd_idx_q;
        vic_cnt_q  <= rd_count;
        vic_rank_q <= rd_rank;
      end
      if (!ent_valid && !free_ok_q) free_idx_q <= rd_idx_q;
    end
    if (state_q == ST_DECIDE) begin
      slot_q       <= dec_slot;
      ref_rank_q   <= dec_ref;
      mode_q.touch <= act_touch;
      mode_q.evict <= need_evict;
      res_q        <= dec_res;
    end
    if (load_out) out_q <= res_q;
  end

  lfu_entry_store #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .IDX_BITS   (IDX_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_key_o    (rd_key),
    .rd_value_o  (rd_value),
    .rd_count_o  (rd_count),
    .rd_rank_o   (rd_rank),
    .we_i        (store_we),
    .wr_addr_i   (dec_slot),
    .wr_key_i    (item_q.key),
    .wr_value_i  (item_q.data_in),
    .wr_count_i  (wr_count),
    .rank_addr_i (rd_idx_q),
    .wr_rank_i   (wr_rank)
  );

  lfu_entry_unit #(
    .COUNT_BITS (COUNT_BITS),
    .RANK_BITS  (IDX_BITS)
  ) u_unit (
    .ent_valid_i (ent_valid),
    .ent_key_i   (rd_key),
    .ent_count_i (rd_count),
    .ent_rank_i  (rd_rank),
    .item_key_i  (item_q.key),
    .vic_ok_i    (vic_ok_q),
    .vic_count_i (vic_cnt_q),
    .vic_rank_i  (vic_rank_q),
    .mode_i      (mode_q),
    .ref_rank_i  (ref_rank_q),
    .flags_o     (flags),
    .new_rank_o  (new_rank)
  );

endmodule

`default_nettype wire

FILE: src/lfu_entry_store.sv
// entry memories: key, value, use count and recency rank
// depends on lfu_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfu_entry_store #(
  parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS,
  parameter int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rd_en_i,
  input  wire logic [IDX_BITS-1:0]          rd_addr_i,
  output logic [lfu_pkg::KEY_BITS-1:0]      rd_key_o,
  output logic [lfu_pkg::DATA_BITS-1:0]     rd_value_o,
  output logic [COUNT_BITS-1:0]             rd_count_o,
  output logic [IDX_BITS-1:0]               rd_rank_o,
  input  wire lfu_pkg::store_we_t           we_i,
  input  wire logic [IDX_BITS-1:0]          wr_addr_i,
  input  wire logic [lfu_pkg::KEY_BITS-1:0] wr_key_i,
  input  wire logic [lfu_pkg::DATA_BITS-1:0] wr_value_i,
  input  wire logic [COUNT_BITS-1:0]        wr_count_i,
  input  wire logic [IDX_BITS-1:0]          rank_addr_i,
  input  wire logic [IDX_BITS-1:0]          wr_rank_i
);
  import lfu_pkg::*;

  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [DATA_BITS-1:0]  value_mem [ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic [IDX_BITS-1:0]   rank_mem  [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i.key_we)   key_mem[wr_addr_i]   <= wr_key_i;
    if (we_i.value_we) value_mem[wr_addr_i] <= wr_value_i;
    if (we_i.count_we) count_mem[wr_addr_i] <= wr_count_i;
    if (we_i.rank_we)  rank_mem[rank_addr_i] <= wr_rank_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o   <= key_mem[rd_addr_i];
      rd_value_o <= value_mem[rd_addr_i];
      rd_count_o <= count_mem[rd_addr_i];
      rd_rank_o  <= rank_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/lfu_entry_unit.sv
// shared per-entry unit: key match, victim compare and rank adjust
// depends on lfu_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfu_entry_unit #(
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS,
  parameter int RANK_BITS  = 4
) (
  input  wire logic                         ent_valid_i,
  input  wire logic [lfu_pkg::KEY_BITS-1:0] ent_key_i,
  input  wire logic [COUNT_BITS-1:0]        ent_count_i,
  input  wire logic [RANK_BITS-1:0]         ent_rank_i,
  input  wire logic [lfu_pkg::KEY_BITS-1:0] item_key_i,
  input  wire logic                         vic_ok_i,
  input  wire logic [COUNT_BITS-1:0]        vic_count_i,
  input  wire logic [RANK_BITS-1:0]         vic_rank_i,
  input  wire lfu_pkg::upd_mode_t           mode_i,
  input  wire logic [RANK_BITS-1:0]         ref_rank_i,
  output lfu_pkg::scan_flags_t              flags_o,
  output logic [RANK_BITS-1:0]              new_rank_o
);
  import lfu_pkg::*;

  logic inc, dec;

  always_comb begin
    flags_o.match  = ent_valid_i && (ent_key_i == item_key_i);
    // lower count wins, equal counts go to the older entry
    flags_o.better = ent_valid_i &&
                     (!vic_ok_i || (ent_count_i < vic_count_i) ||
                      ((ent_count_i == vic_count_i) && (ent_rank_i > vic_rank_i)));
  end

  always_comb begin
    if (mode_i.touch) begin
      inc = ent_rank_i < ref_rank_i;
      dec = 1'b0;
    end else begin
      inc = 1'b1;
      dec = mode_i.evict && (ent_rank_i > ref_rank_i);
    end
    new_rank_o = ent_rank_i + RANK_BITS'(inc) - RANK_BITS'(dec);
  end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// self-checking bench for the lfu cache: a queue-fed driver, a monitor with its own cache model
// and checker, a stalling receiver and a watchdog; depends on lfu_pkg and lfu_cache_replacement
`timescale 1ns / 1ps

module tb_top;
  import lfu_pkg::*;

  localparam int ENTRIES        = DEF_ENTRIES;
  localparam int COUNT_BITS     = DEF_COUNT_BITS;
  localparam int SETTLE_CYCLES  = 80;     // beyond the longest item
  localparam int IDLE_LIMIT     = 20000;  // cycles without any handshake
  localparam int HOLD_CYCLES    = 700;    // long receiver hold-off
  localparam int HOLD_AFTER     = 400;    // items accepted before the hold-off starts
  localparam int POOL_SIZE      = 40;
  localparam int PHASE_ITEMS    = 155;
  localparam int REPORT_MAX     = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data   = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  always #1 clk_i = ~clk_i;

  lfu_cache_replacement #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  // stimulus and bookkeeping
  in_item_t            op_queue[$];
  logic [CFG_BITS-1:0] capacity_queue[$];
  out_item_t           lookup_results[$];
  int                  ops_pushed  = 0;
  int                  ops_taken   = 0;
  int                  cfg_taken   = 0;
  int                  fail_count  = 0;

  // cache model
  logic [CFG_BITS-1:0]   capacity_q = CAP_RESET;
  logic                  slot_valid[ENTRIES];
  logic [KEY_BITS-1:0]   slot_key[ENTRIES];
  logic [DATA_BITS-1:0]  slot_value[ENTRIES];
  logic [COUNT_BITS-1:0] slot_uses[ENTRIES];
  int                    slot_age[ENTRIES];
  int                    cache_fill = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_uses[i]  = '0;
      slot_age[i]   = 0;
    end
  end

  function automatic int first_free_slot();
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_valid[i]) return i;
    end
    return -1;
  endfunction

  // most recent gets age 0, younger entries age by one, use count saturates
  task automatic touch_slot(input int s);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    end
    slot_age[s] = 0;
    if (slot_uses[s] != '1) slot_uses[s]++;
  endtask

  task automatic lfu_lookup(input in_item_t it, output out_item_t res);
    int cap_eff;
    int slot;
    int victim;
    res     = '0;
    cap_eff = (capacity_q > ENTRIES) ? ENTRIES : int'(capacity_q);
    slot    = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && slot_valid[i] && slot_key[i] == it.key) slot = i;
    end
    if (it.op == OP_GET) begin
      if (slot >= 0) begin
        res.hit      = 1'b1;
        res.data_out = slot_value[slot];
        touch_slot(slot);
      end
    end else if (cap_eff != 0) begin
      if (slot >= 0) begin
        res.hit          = 1'b1;
        slot_value[slot] = it.data_in;
        touch_slot(slot);
        res.stored       = 1'b1;
      end else begin
        if (cache_fill >= cap_eff || first_free_slot() < 0) begin
          // lowest use count, oldest among equals
          victim = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            slot_valid[victim] = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot_valid[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
            end
            if (cache_fill > 0) cache_fill--;
            res.evicted = 1'b1;
          end
        end
        slot = first_free_slot();
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) slot_age[i]++;
          end
          slot_valid[slot] = 1'b1;
          slot_key[slot]   = it.key;
          slot_value[slot] = it.data_in;
          slot_uses[slot]  = COUNT_BITS'(1);
          slot_age[slot]   = 0;
          cache_fill++;
          res.stored       = 1'b1;
        end
      end
    end
  endtask

  // driver: bursts of items with random gaps, no gaps while the receiver holds off
  int burst_left = 0;
  int gap_left   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk_i) begin : drive_proc
    logic     busy;
    in_item_t nxt;
    if (rst_ni) begin
      busy = in_valid && !in_ready_o;
      if (!busy) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          nxt = op_queue.pop_front();
          in_data  <= nxt;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // configuration driver: one write in flight at a time
  always @(posedge clk_i) begin : cfg_proc
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        cfg_valid <= 1'b0;
      end else if (!cfg_valid && capacity_queue.size() > 0) begin
        cfg_data  <= capacity_queue.pop_front();
        cfg_valid <= 1'b1;
      end
    end
  end

  // receiver: stall pattern that changes mode now and then, plus one long hold-off
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk_i) begin : recv_proc
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && ops_taken >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(20, 200);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: begin
            rdy = 1'b1;
          end
          1: begin
            rdy = ($urandom_range(0, 3) != 0);
          end
          2: begin
            rdy = ($urandom_range(0, 3) == 0);
          end
          default: begin
            rdy = ~out_ready;
          end
        endcase
      end
    end
    out_ready <= rdy;
  end

  // monitor: checks each result against the oldest prediction, then predicts new items
  always @(posedge clk_i) begin : mon_proc
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        capacity_q = cfg_data;
        cfg_taken <= cfg_taken + 1;
      end
      if (out_valid_o && out_ready) begin
        got = out_data_o;
        if (lookup_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result: hit=%0d data=%h evicted=%0d stored=%0d",
                     got.hit, got.data_out, got.evicted, got.stored);
        end else begin
          want = lookup_results.pop_front();
          if (got.hit !== want.hit || got.data_out !== want.data_out ||
              got.evicted !== want.evicted || got.stored !== want.stored) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"mismatch: expected hit=%0d data=%h evicted=%0d stored=%0d, ",
                        "got hit=%0d data=%h evicted=%0d stored=%0d"},
                       want.hit, want.data_out, want.evicted, want.stored,
                       got.hit, got.data_out, got.evicted, got.stored);
          end
        end
      end
      if (in_valid && in_ready_o) begin
        lfu_lookup(in_data, want);
        lookup_results.push_back(want);
        ops_taken <= ops_taken + 1;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog_proc
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lfu_cache_replacement regression: fail");
        $finish;
      end
    end
  end

  task automatic queue_op(input logic op, input logic [31:0] key, input logic [31:0] data);
    in_item_t it;
    it.op      = op;
    it.key     = key;
    it.data_in = data;
    op_queue.push_back(it);
    ops_pushed++;
  endtask

  // all items taken, all results back, then let the block settle
  task automatic drain_and_settle();
    while (op_queue.size() != 0 || ops_taken != ops_pushed || lookup_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CFG_BITS-1:0] value);
    int target;
    target = cfg_taken + 1;
    capacity_queue.push_back(value);
    while (cfg_taken != target) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin : stim_proc
    int          caps[11];
    logic [31:0] key_pool[POOL_SIZE];
    int          pool_n;
    int          cap_eff;
    int          idx;
    logic        op;
    logic [31:0] k;
    logic [31:0] d;

    caps = '{16, 31, 1, 0, 2, 17, 5, 8, 16, 3, 12};
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[3] = 32'h8000_0000;
    key_pool[5] = 32'h7fff_ffff;
    key_pool[7] = 32'h0000_0000;
    key_pool[9] = 32'hffff_ffff;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty miss, extreme keys and values, update, fill and evict
    queue_op(OP_GET, 32'h0000_0000, 32'h0);
    queue_op(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_op(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_op(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_op(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
    queue_op(OP_GET, 32'h8000_0000, 32'h0);
    queue_op(OP_GET, 32'hffff_ffff, 32'h0);
    queue_op(OP_PUT, 32'h7fff_ffff, 32'h1234_5678);
    for (int i = 1; i <= 12; i++) queue_op(OP_PUT, i, $urandom);
    // full: the oldest single-use entry goes
    queue_op(OP_PUT, 32'd100, 32'hcafe_f00d);
    queue_op(OP_GET, 32'd1, 32'h0);
    drain_and_settle();

    // capacity zero: puts ignored, gets still see old entries
    write_capacity(5'd0);
    queue_op(OP_PUT, 32'd200, 32'h5555_aaaa);
    queue_op(OP_GET, 32'h8000_0000, 32'h0);
    drain_and_settle();

    // capacity below occupancy: each insert evicts exactly one
    write_capacity(5'd3);
    queue_op(OP_PUT, 32'd300, 32'haaaa_5555);
    queue_op(OP_GET, 32'd300, 32'h0);
    drain_and_settle();

    // random phases over a spread of capacities
    for (int ph = 0; ph < 11; ph++) begin
      write_capacity(CFG_BITS'(caps[ph]));
      cap_eff = (caps[ph] > ENTRIES) ? ENTRIES : caps[ph];
      pool_n  = cap_eff + $urandom_range(1, 6);
      if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
          0, 1: begin
            k = $urandom;
          end
          2: begin
            k = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
          end
          default: begin
            // a couple of hot keys build up high use counts
            idx = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, pool_n - 1);
            k   = key_pool[idx];
          end
        endcase
        case ($urandom_range(0, 15))
          0: begin
            d = 32'h0000_0000;
          end
          1: begin
            d = 32'h8000_0000;
          end
          2: begin
            d = 32'h7fff_ffff;
          end
          3: begin
            d = 32'hffff_ffff;
          end
          default: begin
            d = $urandom;
          end
        endcase
        queue_op(op, k, d);
      end
      drain_and_settle();
    end

    if (fail_count == 0 && lookup_results.size() == 0) begin
      $display("lfu_cache_replacement regression: pass");
    end else begin
      $display("lfu_cache_replacement regression: fail");
    end
    $finish;
  end

endmodule
